// File: rtl/core/cpdt_pkg.sv
// ----------------------------------------------------------------------------
// cpdt_pkg
// Shared types and constants of the colour palette table.
// ----------------------------------------------------------------------------
`default_nettype none

package cpdt_pkg;

   // Table geometry.
   localparam int DEPTH   = 256;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int COLOR_W = 24;

   // Field widths of the channels.
   localparam int CMD_W      = 2;
   localparam int COMP_W     = 8;
   localparam int INDEX_W    = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 24;

   // Command codes. The unused code behaves as a lookup.
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_BG_ENABLE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BG_COLOR  = 1'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic             found;
      logic             full;
      logic [CNT_W-1:0] count;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/core/cpdt_if.sv
// ----------------------------------------------------------------------------
// cpdt_if
// Request, response and register-write channels of the palette table.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpdt_req_if;
   logic                         valid;
   logic                         ready;
   logic [cpdt_pkg::CMD_W-1:0]   cmd;
   logic [cpdt_pkg::COMP_W-1:0]  red;
   logic [cpdt_pkg::COMP_W-1:0]  green;
   logic [cpdt_pkg::COMP_W-1:0]  blue;
   logic                         clockwise;

   modport source (output valid, cmd, red, green, blue, clockwise, input ready);
   modport sink   (input valid, cmd, red, green, blue, clockwise, output ready);
endinterface

interface cpdt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [cpdt_pkg::INDEX_W-1:0]  index;
   logic                          found;
   logic                          full_res;
   logic [cpdt_pkg::CNT_W-1:0]    count;

   modport source (output valid, index, found, full_res, count, input ready);
   modport sink   (input valid, index, found, full_res, count, output ready);
endinterface

interface cpdt_csr_if;
   logic                             valid;
   logic                             ready;
   logic [cpdt_pkg::CSR_IDX_W-1:0]   index;
   logic [cpdt_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/cpdt_ram.sv
// ----------------------------------------------------------------------------
// cpdt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module cpdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: rtl/core/colour_palette_dedup_table.sv
// A clear answers without a search; an insert or lookup reads the entries in
// order until the first match or the end of the table.
// The table takes one item at a time: no new request is accepted while an
// item is searched or its result is held. The search is set by the single
// read port of the palette RAM, which compares one entry per cycle.
// Reset clears the state, entry count, output valid and background registers; the palette RAM is not cleared.
// ----------------------------------------------------------------------------
// colour_palette_dedup_table
// Palette of unique 24-bit colours with insert-if-absent, lookup and clear,
// searched sequentially through a single synchronous RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module colour_palette_dedup_table (
   input  wire logic   clock,
   input  wire logic   reset,
   cpdt_req_if.sink    req_if,
   cpdt_rsp_if.source  rsp_if,
   cpdt_csr_if.sink    csr_if
);

   localparam logic [cpdt_pkg::CNT_W-1:0] FULL_COUNT = cpdt_pkg::CNT_W'(cpdt_pkg::DEPTH);

   cpdt_pkg::state_type  state_ff, state_in;
   logic [cpdt_pkg::CMD_W-1:0]   cmd_ff, cmd_in;
   logic [cpdt_pkg::COLOR_W-1:0] colour_ff, colour_in;
   logic [cpdt_pkg::IDX_W-1:0]   cmp_ff, cmp_in;
   logic [cpdt_pkg::CNT_W-1:0]   count_ff, count_in;
   cpdt_pkg::result_type pend_ff, pend_in;
   cpdt_pkg::result_type out_ff;
   logic                 out_valid_ff;
   logic                 bg_enable_ff;
   logic [cpdt_pkg::COLOR_W-1:0] bg_color_ff;

   logic [cpdt_pkg::COLOR_W-1:0] req_colour;
   logic [cpdt_pkg::CMD_W-1:0]   act_cmd;
   logic [cpdt_pkg::COLOR_W-1:0] act_colour;
   logic                         accept;
   logic                         load_out;
   logic                         hit, miss, clear_done;
   logic [cpdt_pkg::IDX_W-1:0]   hit_idx;

   logic                         ram_we;
   logic [cpdt_pkg::IDX_W-1:0]   ram_waddr;
   logic [cpdt_pkg::COLOR_W-1:0] ram_wdata;
   logic [cpdt_pkg::IDX_W-1:0]   ram_raddr;
   logic [cpdt_pkg::COLOR_W-1:0] ram_rdata;

   // Background substitution happens before anything else.
   assign req_colour = (bg_enable_ff && req_if.clockwise) ? bg_color_ff
                                                          : {req_if.red, req_if.green, req_if.blue};

   assign req_if.ready = (state_ff == cpdt_pkg::ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign load_out     = (state_ff == cpdt_pkg::ST_HOLD) && (!out_valid_ff || rsp_if.ready);

   assign act_cmd    = (state_ff == cpdt_pkg::ST_IDLE) ? req_if.cmd : cmd_ff;
   assign act_colour = (state_ff == cpdt_pkg::ST_IDLE) ? req_colour : colour_ff;

   assign csr_if.ready = 1'b1;

   cpdt_ram #(
      .WIDTH (cpdt_pkg::COLOR_W),
      .DEPTH (cpdt_pkg::DEPTH)
   ) u_palette (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cpdt_pkg::ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
         bg_enable_ff <= 1'b0;
         bg_color_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_if.valid) begin
            case (csr_if.index)
               cpdt_pkg::REG_BG_ENABLE: bg_enable_ff <= csr_if.data[0];
               cpdt_pkg::REG_BG_COLOR:  bg_color_ff  <= csr_if.data[cpdt_pkg::COLOR_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      colour_ff <= colour_in;
      cmp_ff    <= cmp_in;
      pend_ff   <= pend_in;
      if (load_out) begin
         out_ff <= pend_ff;
      end
   end

   // Each SEARCH cycle compares the entry read in the previous cycle and
   // issues the read of the next one. A palette write happens only when an
   // item finishes, and the next item's first read is issued only after the
   // HOLD state, so a read never overlaps a write to the same entry.
   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      colour_in  = colour_ff;
      cmp_in     = cmp_ff;
      count_in   = count_ff;
      pend_in    = pend_ff;
      ram_we     = 1'b0;
      ram_waddr  = count_ff[cpdt_pkg::IDX_W-1:0];
      ram_wdata  = act_colour;
      ram_raddr  = '0;
      hit        = 1'b0;
      miss       = 1'b0;
      clear_done = 1'b0;
      hit_idx    = cmp_ff;

      case (state_ff)
         cpdt_pkg::ST_IDLE: begin
            if (accept) begin
               cmd_in    = req_if.cmd;
               colour_in = req_colour;
               cmp_in    = '0;
               if (req_if.cmd == cpdt_pkg::CMD_CLEAR) begin
                  clear_done = 1'b1;
               end else if (count_ff == '0) begin
                  miss = 1'b1;
               end else begin
                  state_in = cpdt_pkg::ST_SEARCH;
               end
            end
         end
         cpdt_pkg::ST_SEARCH: begin
            if (ram_rdata == colour_ff) begin
               hit = 1'b1;
            end else if (cpdt_pkg::CNT_W'(cmp_ff) + 1'b1 == count_ff) begin
               miss = 1'b1;
            end else begin
               cmp_in    = cmp_ff + 1'b1;
               ram_raddr = cmp_ff + 1'b1;
            end
         end
         cpdt_pkg::ST_HOLD: begin
            if (load_out) begin
               state_in = cpdt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cpdt_pkg::ST_IDLE;
         end
      endcase

      if (clear_done) begin
         count_in = '0;
         pend_in  = '0;
         state_in = cpdt_pkg::ST_HOLD;
      end else if (hit) begin
         pend_in.idx   = hit_idx;
         pend_in.found = 1'b1;
         pend_in.full  = 1'b0;
         pend_in.count = count_ff;
         state_in      = cpdt_pkg::ST_HOLD;
      end else if (miss) begin
         pend_in.idx   = '0;
         pend_in.found = 1'b0;
         pend_in.full  = 1'b0;
         pend_in.count = count_ff;
         if (act_cmd == cpdt_pkg::CMD_INSERT) begin
            if (count_ff < FULL_COUNT) begin
               ram_we        = 1'b1;
               pend_in.idx   = count_ff[cpdt_pkg::IDX_W-1:0];
               count_in      = count_ff + 1'b1;
               pend_in.count = count_ff + 1'b1;
            end else begin
               pend_in.full = 1'b1;
            end
         end
         state_in = cpdt_pkg::ST_HOLD;
      end
   end

   assign rsp_if.valid    = out_valid_ff;
   assign rsp_if.index    = cpdt_pkg::INDEX_W'(out_ff.idx);
   assign rsp_if.found    = out_ff.found;
   assign rsp_if.full_res = out_ff.full;
   assign rsp_if.count    = out_ff.count;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count beyond table depth");

   a_write_room: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (count_ff < FULL_COUNT) && (act_cmd == cpdt_pkg::CMD_INSERT))
      else $error("palette write without room or without insert");

   a_write_counts: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> count_ff == $past(count_ff) + 1'b1)
      else $error("palette write did not advance the entry count");

   a_search_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cpdt_pkg::ST_SEARCH) |-> (cpdt_pkg::CNT_W'(cmp_ff) < count_ff))
      else $error("search pointer past the valid entries");

   a_rsp_from_hold: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == cpdt_pkg::ST_HOLD))
      else $error("response raised outside the hold state");

endmodule

`default_nettype wire

// File: tb/sv/colour_palette_dedup_table_test.sv
// ----------------------------------------------------------------------------
// colour_palette_dedup_table_test
// Self-checking bench for the colour palette table. Requests, responses and
// register writes go through the channel interfaces, with random gaps on the
// request and response sides. A scoreboard keeps its own copy of the palette and the background
// registers, predicts one response per accepted request and compares every
// response field by field, in order.
// ----------------------------------------------------------------------------

module colour_palette_dedup_table_test;
   timeunit 1ns;
   timeprecision 1ps;

   import cpdt_pkg::*;

   // Command code that the block treats as a lookup.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam int PHASES       = 6;
   localparam int PHASE_BUDGET = 250;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 300;
   localparam int REPORT_MAX   = 10;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [COMP_W-1:0] red;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] blue;
      logic              clockwise;
   } colour_request_t;

   class palette_scoreboard;
      logic [COLOR_W-1:0] stored_colours [DEPTH];
      int                 entries = 0;
      logic               bg_enable = 1'b0;
      logic [COLOR_W-1:0] bg_colour = '0;
      result_type         expected_results [$];
      int                 failures = 0;

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == REG_BG_ENABLE) begin
            bg_enable = data[0];
         end else begin
            bg_colour = data[COLOR_W-1:0];
         end
      endfunction

      // Works out the response to one accepted request and updates the table.
      function void note_request(colour_request_t r);
         logic [COLOR_W-1:0] colour;
         result_type         res;
         logic               hit;
         colour = {r.red, r.green, r.blue};
         if (bg_enable && r.clockwise) begin
            colour = bg_colour;
         end
         res = '0;
         hit = 1'b0;
         if (r.cmd == CMD_CLEAR) begin
            entries = 0;
         end else begin
            for (int i = 0; i < entries; i++) begin
               if (!hit && stored_colours[i] == colour) begin
                  hit       = 1'b1;
                  res.idx   = i[IDX_W-1:0];
                  res.found = 1'b1;
               end
            end
            if (!hit && r.cmd == CMD_INSERT) begin
               if (entries < DEPTH) begin
                  stored_colours[entries] = colour;
                  res.idx = entries[IDX_W-1:0];
                  entries++;
               end else begin
                  res.full = 1'b1;
               end
            end
         end
         res.count = entries[CNT_W-1:0];
         expected_results.push_back(res);
      endfunction

      function void check_result(result_type got);
         result_type exp;
         if (expected_results.size() == 0) begin
            failures++;
            if (failures <= REPORT_MAX) begin
               $display("%0t: response with nothing outstanding: index %0d count %0d",
                        $realtime, got.idx, got.count);
            end
            return;
         end
         exp = expected_results.pop_front();
         if (got.idx !== exp.idx || got.found !== exp.found || got.full !== exp.full ||
             got.count !== exp.count) begin
            failures++;
            if (failures <= REPORT_MAX) begin
               $display("%0t: result mismatch: expected index %0d found %0b full %0b count %0d",
                        $realtime, exp.idx, exp.found, exp.full, exp.count);
               $display("%0t:                  got      index %0d found %0b full %0b count %0d",
                        $realtime, got.idx, got.found, got.full, got.count);
            end
         end
      endfunction

      function int outstanding();
         return expected_results.size();
      endfunction

      function bit clean();
         return failures == 0 && expected_results.size() == 0;
      endfunction
   endclass

   logic clock;
   logic reset;

   cpdt_req_if req_bus ();
   cpdt_rsp_if rsp_bus ();
   cpdt_csr_if csr_bus ();

   colour_palette_dedup_table dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   palette_scoreboard sb;
   bit                req_quiet;
   bit                rsp_quiet;
   int                sent_in_phase;
   int                idle_cycles;

   always #1 clock = ~clock;

   // Ends the run if the block stops moving transfers altogether.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
                   (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_colour(input logic [CMD_W-1:0] cmd, input logic [COLOR_W-1:0] colour,
                              input logic cw);
      int              gap;
      colour_request_t r;
      gap = req_quiet ? 0 : $urandom_range(0, 15);
      r.cmd       = cmd;
      r.red       = colour[23:16];
      r.green     = colour[15:8];
      r.blue      = colour[7:0];
      r.clockwise = cw;
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.cmd       = r.cmd;
      req_bus.red       = r.red;
      req_bus.green     = r.green;
      req_bus.blue      = r.blue;
      req_bus.clockwise = r.clockwise;
      req_bus.valid     = 1'b1;
      forever begin
         @(posedge clock);
         if (req_bus.ready) break;
      end
      sb.note_request(r);
      sent_in_phase++;
   endtask

   task automatic collect_results();
      result_type got;
      int         stall;
      forever begin
         stall = rsp_quiet ? 0 : $urandom_range(0, 15);
         @(negedge clock);
         if (stall > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         forever begin
            @(posedge clock);
            if (rsp_bus.valid) break;
         end
         got.idx   = rsp_bus.index;
         got.found = rsp_bus.found;
         got.full  = rsp_bus.full_res;
         got.count = rsp_bus.count;
         sb.check_result(got);
      end
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_bus.index = idx;
      csr_bus.data  = data;
      csr_bus.valid = 1'b1;
      forever begin
         @(posedge clock);
         if (csr_bus.ready) break;
      end
      sb.set_register(idx, data);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // Drops the request valid and waits until every response has come back.
   task automatic settle();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   task automatic directed_basic();
      send_colour(CMD_LOOKUP, 24'h000000, 1'b0);
      send_colour(CMD_CLEAR,  24'h000000, 1'b0);
      send_colour(CMD_INSERT, 24'h000000, 1'b1);
      send_colour(CMD_INSERT, 24'hFFFFFF, 1'b0);
      send_colour(CMD_INSERT, 24'h000000, 1'b0);
      send_colour(CMD_INSERT, 24'hFF0000, 1'b0);
      send_colour(CMD_LOOKUP, 24'hFFFFFF, 1'b0);
      send_colour(CMD_LOOKUP, 24'h00FF00, 1'b0);
      send_colour(CMD_UNUSED, 24'hFF0000, 1'b0);
      send_colour(CMD_UNUSED, 24'h0000FF, 1'b0);
      send_colour(CMD_LOOKUP, 24'h0000FF, 1'b0);
      send_colour(CMD_CLEAR,  24'hFFFFFF, 1'b1);
      // Stale entries past the count must not match after a clear.
      send_colour(CMD_LOOKUP, 24'hFFFFFF, 1'b0);
      send_colour(CMD_INSERT, 24'h00FF00, 1'b0);
   endtask

   task automatic directed_background();
      send_colour(CMD_INSERT, 24'h123456, 1'b1);
      send_colour(CMD_LOOKUP, 24'h000000, 1'b1);
      send_colour(CMD_INSERT, 24'hFFFFFF, 1'b0);
      send_colour(CMD_INSERT, 24'h0000FF, 1'b0);
      send_colour(CMD_LOOKUP, 24'h0000FF, 1'b1);
      send_colour(CMD_CLEAR,  24'h0000FF, 1'b1);
   endtask

   // Fills the table to the last entry, then probes it while full.
   task automatic fill_table();
      logic [COLOR_W-1:0] base;
      logic [COLOR_W-1:0] probe;
      base      = COLOR_W'($urandom_range(0, 24'hFFFFFF));
      req_quiet = ($urandom_range(0, 2) == 0);
      rsp_quiet = ($urandom_range(0, 2) == 0);
      send_colour(CMD_CLEAR, base, 1'b0);
      for (int k = 0; k < DEPTH; k++) begin
         send_colour(CMD_INSERT, COLOR_W'(base + k),
                     sb.bg_enable ? 1'b0 : 1'($urandom_range(0, 1)));
      end
      send_colour(CMD_INSERT, COLOR_W'(base + DEPTH), 1'b0);
      send_colour(CMD_INSERT, COLOR_W'(base + DEPTH - 1), 1'b0);
      repeat (10) begin
         probe = COLOR_W'(base + $urandom_range(0, 2 * DEPTH - 1));
         send_colour($urandom_range(0, 1) ? CMD_INSERT : CMD_LOOKUP, probe,
                     1'($urandom_range(0, 1)));
      end
   endtask

   // A short run over a handful of colours, so that hits are common.
   task automatic pool_episode();
      logic [COLOR_W-1:0] pool [6];
      logic [COLOR_W-1:0] colour;
      logic [CMD_W-1:0]   cmd;
      int                 pick;
      int                 n;
      foreach (pool[i]) pool[i] = COLOR_W'($urandom_range(0, 24'hFFFFFF));
      pool[0]   = sb.bg_colour;
      pool[1]   = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
      req_quiet = ($urandom_range(0, 3) == 0);
      rsp_quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1)) begin
         send_colour(CMD_CLEAR, COLOR_W'($urandom_range(0, 24'hFFFFFF)),
                     1'($urandom_range(0, 1)));
      end
      n = $urandom_range(1, 40);
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            cmd = CMD_INSERT;
         end else if (pick < 85) begin
            cmd = CMD_LOOKUP;
         end else if (pick < 93) begin
            cmd = CMD_UNUSED;
         end else begin
            cmd = CMD_CLEAR;
         end
         colour = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 5)]
                                             : COLOR_W'($urandom_range(0, 24'hFFFFFF));
         send_colour(cmd, colour, 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] colour_setting;
      logic                  enable_setting;
      sb                = new();
      clock             = 1'b0;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.cmd       = CMD_CLEAR;
      req_bus.red       = '0;
      req_bus.green     = '0;
      req_bus.blue      = '0;
      req_bus.clockwise = 1'b0;
      rsp_bus.ready     = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = REG_BG_ENABLE;
      csr_bus.data      = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      fork
         collect_results();
      join_none

      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         case (phase)
            0: begin
               enable_setting = 1'b0;
               colour_setting = 24'h000000;
            end
            1: begin
               enable_setting = 1'b1;
               colour_setting = 24'hFFFFFF;
            end
            2: begin
               enable_setting = 1'b1;
               colour_setting = 24'h000000;
            end
            default: begin
               enable_setting = (phase != 4);
               colour_setting = CSR_DATA_W'($urandom_range(0, 24'hFFFFFF));
            end
         endcase
         write_register(REG_BG_ENABLE, CSR_DATA_W'(enable_setting));
         write_register(REG_BG_COLOR, colour_setting);
         sent_in_phase = 0;
         req_quiet     = 1'b0;
         rsp_quiet     = 1'b0;
         if (phase == 0) directed_basic();
         if (phase == 1) directed_background();
         if (phase == 2 || phase == 4) fill_table();
         while (sent_in_phase < PHASE_BUDGET) pool_episode();
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.clean()) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
